[hw/rtl/stbs_pkg.sv]
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int VALUE_W         = 32;
  localparam int INDEX_W         = 4;
  localparam int COUNT_W         = 5;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic hit;
    logic cont;
  } sts_t;

endpackage

[hw/rtl/stbs_if.sv]
interface stbs_req_if;
  logic                             valid;
  logic                             ready;
  logic                             func;
  logic [stbs_pkg::INDEX_W-1:0]     entry_index;
  logic signed [stbs_pkg::VALUE_W-1:0] item_value;

  modport source (output valid, func, entry_index, item_value, input ready);
  modport sink   (input valid, func, entry_index, item_value, output ready);
endinterface

interface stbs_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [stbs_pkg::INDEX_W-1:0] position;

  modport source (output valid, found, position, input ready);
  modport sink   (input valid, found, position, output ready);
endinterface

interface stbs_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [stbs_pkg::COUNT_W-1:0] entry_count;

  modport source (output valid, entry_count, input ready);
  modport sink   (input valid, entry_count, output ready);
endinterface

[hw/rtl/sorted_table_binary_search_unit.sv]
// Table write: entry stored at the edge that takes the word, no result word.
// Search: an issue step, then probe steps (none for an empty table), then a result step; one search
// in flight at a time, one probe per cycle through the single synchronous table read port.
// Reset: control cleared, entry_count set to 16, table contents undefined until written.
module sorted_table_binary_search_unit #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  stbs_req_if.sink   req,
  stbs_rsp_if.source rsp,
  stbs_cfg_if.sink   cfg
);
  import stbs_pkg::*;

  cmd_t               cmd;
  sts_t               sts;
  logic               ctl_req_ready;
  logic               ctl_rsp_valid;
  logic               dp_found;
  logic [INDEX_W-1:0] dp_position;

  assign cfg.ready    = 1'b1;
  assign req.ready    = ctl_req_ready;
  assign rsp.valid    = ctl_rsp_valid;
  assign rsp.found    = dp_found;
  assign rsp.position = dp_position;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_func  (req.func),
    .req_ready (ctl_req_ready),
    .rsp_valid (ctl_rsp_valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  stbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg.valid),
    .cfg_count   (cfg.entry_count),
    .entry_index (req.entry_index),
    .item_value  (req.item_value),
    .found       (dp_found),
    .position    (dp_position)
  );

endmodule

[hw/rtl/stbs_datapath.sv]
module stbs_datapath #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  stbs_pkg::cmd_t                      cmd,
  output stbs_pkg::sts_t                      sts,
  input  logic                                cfg_we,
  input  logic [stbs_pkg::COUNT_W-1:0]        cfg_count,
  input  logic [stbs_pkg::INDEX_W-1:0]        entry_index,
  input  logic signed [stbs_pkg::VALUE_W-1:0] item_value,
  output logic                                found,
  output logic [stbs_pkg::INDEX_W-1:0]        position
);
  import stbs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [VALUE_W-1:0] mem [TABLE_DEPTH];
  logic signed [VALUE_W-1:0] rdata;
  logic signed [VALUE_W-1:0] key;
  logic [COUNT_W-1:0]        entry_count;
  logic [CW-1:0]             n_clamp, nm1, lo, hi, lo_new, hi_new, span, mid_ext;
  logic [AW-1:0]             mid, mid_start, mid_step, rd_addr;
  logic                      gt, hit, cont;
  logic                      res_found;
  logic [INDEX_W-1:0]        res_pos;

  always_comb begin
    n_clamp   = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count);
    nm1       = n_clamp - CW'(1);
    mid_start = AW'(nm1 >> 1);
    hit       = (rdata == key);
    gt        = (rdata > key);
    mid_ext   = CW'(mid);
    lo_new    = gt ? lo : mid_ext + CW'(1);
    hi_new    = gt ? mid_ext : hi;
    cont      = (lo_new < hi_new);
    span      = hi_new - lo_new - CW'(1);
    mid_step  = AW'(lo_new + (span >> 1));
    rd_addr   = cmd.start ? mid_start : mid_step;
    sts.empty = (n_clamp == '0);
    sts.hit   = hit;
    sts.cont  = cont;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_RESET;
    end else if (cfg_we) begin
      entry_count <= cfg_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && (32'(entry_index) < 32'(TABLE_DEPTH))) begin
      mem[AW'(entry_index)] <= item_value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start || cmd.step) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key       <= item_value;
      lo        <= '0;
      hi        <= n_clamp;
      mid       <= mid_start;
      res_found <= 1'b0;
      res_pos   <= '0;
    end else if (cmd.step) begin
      lo  <= lo_new;
      hi  <= hi_new;
      mid <= mid_step;
      if (hit) begin
        res_found <= 1'b1;
        res_pos   <= INDEX_W'(mid);
      end
    end
    if (cmd.load_out) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

endmodule

[hw/rtl/stbs_ctrl.sv]
module stbs_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_func,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output stbs_pkg::cmd_t cmd,
  input  stbs_pkg::sts_t sts
);
  import stbs_pkg::*;

  state_t state, state_next;
  logic   rsp_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    rsp_valid_next = rsp_valid && !rsp_ready;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          if (req_func == FUNC_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = sts.empty ? ST_RESULT : ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        cmd.step = 1'b1;
        if (sts.hit || !sts.cont) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.load_out   = 1'b1;
          rsp_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!rsp_valid || rsp_ready))
    else $error("result word loaded over an untaken one");

  a_hit_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PROBE && sts.hit) |=> state == ST_RESULT)
    else $error("search continued after a match");

  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_func == FUNC_SEARCH) |=> !req_ready)
    else $error("new word taken during a search");

  a_write_stays: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready && req_func == FUNC_WRITE) |=> state == ST_IDLE)
    else $error("table write left idle");

endmodule

[sim/sorted_table_binary_search_unit_test.sv]
`timescale 1ns / 100ps

module sorted_table_binary_search_unit_test;
  import stbs_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASES = 12;
  localparam int SEARCHES_PER_PHASE = 85;

  typedef struct {
    logic                      func;
    logic [INDEX_W-1:0]        idx;
    logic signed [VALUE_W-1:0] value;
  } table_op_t;

  typedef struct {
    logic               found;
    logic [INDEX_W-1:0] position;
  } lookup_t;

  logic clk = 1'b0;
  logic rst;

  stbs_req_if req_ch ();
  stbs_rsp_if rsp_ch ();
  stbs_cfg_if cfg_ch ();

  sorted_table_binary_search_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  table_op_t                 queued_ops[$];
  lookup_t                   pending_lookups[$];
  logic signed [VALUE_W-1:0] table_copy [DEPTH];
  logic signed [VALUE_W-1:0] plan_table [DEPTH];
  logic [COUNT_W-1:0]        active_count;
  logic                      no_idle = 1'b0;
  int                        req_gap;
  int                        rsp_wait;
  int                        words_seen;
  int                        quiet_cycles;
  int                        faults = 0;

  logic signed [VALUE_W-1:0] seed_table [DEPTH] = '{
    VAL_MIN, -5, -5, -5, -1, 0, 0, 3, 7, 7, 7, 7, 100, 1000, VAL_MAX - 1, VAL_MAX
  };
  logic signed [VALUE_W-1:0] probe_keys [9] = '{
    VAL_MIN, VAL_MAX, -5, 0, 7, 4, -3, VAL_MAX - 2, 1000
  };
  int phase_counts [PHASES] = '{16, 31, 0, 1, 17, 8, 2, -1, 3, -1, 15, 16};

  function automatic int draw_gap();
    if (no_idle || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 7);
  endfunction

  function automatic lookup_t lookup(input logic signed [VALUE_W-1:0] key);
    lookup_t r;
    int lo;
    int hi;
    int mid;
    r.found = 1'b0;
    r.position = '0;
    lo = 0;
    hi = ((int'(active_count) > DEPTH) ? DEPTH : int'(active_count)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_copy[mid] == key) begin
        r.found = 1'b1;
        r.position = mid[INDEX_W-1:0];
        return r;
      end
      if (table_copy[mid] > key) hi = mid - 1;
      else lo = mid + 1;
    end
    return r;
  endfunction

  task automatic plan_write(input int idx, input logic signed [VALUE_W-1:0] val);
    queued_ops.push_back('{FUNC_WRITE, idx[INDEX_W-1:0], val});
    plan_table[idx] = val;
  endtask

  task automatic plan_search(input logic signed [VALUE_W-1:0] key);
    int junk_idx;
    junk_idx = $urandom_range(0, DEPTH - 1);
    queued_ops.push_back('{FUNC_SEARCH, junk_idx[INDEX_W-1:0], key});
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (queued_ops.size() != 0 || pending_lookups.size() != 0 || req_ch.valid);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // request driver; the shadow table and expected lookups follow accepted words
  always @(posedge clk) begin
    logic offer;
    table_op_t op;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.func <= FUNC_WRITE;
      req_ch.entry_index <= '0;
      req_ch.item_value <= '0;
      req_gap = 0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.func == FUNC_SEARCH) pending_lookups.push_back(lookup(req_ch.item_value));
        else table_copy[req_ch.entry_index] = req_ch.item_value;
        offer = 1'b0;
        req_gap = draw_gap();
      end
      if (!offer) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (queued_ops.size() > 0) begin
          op = queued_ops.pop_front();
          req_ch.func <= op.func;
          req_ch.entry_index <= op.idx;
          req_ch.item_value <= op.value;
          offer = 1'b1;
        end
      end
      req_ch.valid <= offer;
    end
  end

  always @(posedge clk) begin
    if (rst) active_count <= COUNT_RESET;
    else if (cfg_ch.valid && cfg_ch.ready) active_count <= cfg_ch.entry_count;
  end

  // result monitor, with a long hold-off now and then
  always @(posedge clk) begin
    lookup_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      rsp_wait = 0;
      words_seen = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        words_seen++;
        if (pending_lookups.size() == 0) begin
          $error("unexpected result word: found %0d position %0d",
                 rsp_ch.found, rsp_ch.position);
          faults++;
        end else begin
          want = pending_lookups.pop_front();
          if (rsp_ch.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, rsp_ch.found);
            faults++;
          end
          if (rsp_ch.position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
            faults++;
          end
        end
        rsp_wait = (words_seen % 400 == 100) ? HOLD_CYCLES : draw_gap();
      end
      if (rsp_wait > 0) begin
        rsp_wait--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int count;
    int mode;
    int r;
    int step;
    longint v;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = FUNC_WRITE;
    req_ch.entry_index = '0;
    req_ch.item_value = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.entry_count = '0;

    // sorted table with duplicates and both extremes, then edge keys
    for (int i = 0; i < DEPTH; i++) plan_write(i, seed_table[i]);
    foreach (probe_keys[i]) plan_search(probe_keys[i]);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      count = (phase_counts[p] < 0) ? $urandom_range(0, 31) : phase_counts[p];
      @(posedge clk);
      cfg_ch.valid <= 1'b1;
      cfg_ch.entry_count <= count[COUNT_W-1:0];
      no_idle <= (p % 4 == 3);
      do @(posedge clk);
      while (!cfg_ch.ready);
      cfg_ch.valid <= 1'b0;
      @(negedge clk);

      mode = $urandom_range(0, 3);
      r = $urandom();
      case (mode)
        0: begin
          v = r;
          step = 2;
        end
        1: begin
          v = VAL_MIN;
          step = 1 << 29;
        end
        2: begin
          v = r;
          step = 0;
        end
        default: begin
          v = -longint'($urandom_range(0, 1 << 30));
          step = 1 << 24;
        end
      endcase
      for (int i = 0; i < DEPTH; i++) begin
        plan_write(i, v[VALUE_W-1:0]);
        v += $urandom_range(0, step);
        if (v > VAL_MAX) v = VAL_MAX;
      end

      for (int k = 0; k < SEARCHES_PER_PHASE; k++) begin
        r = $urandom_range(0, 99);
        if (r < 8) plan_write($urandom_range(0, DEPTH - 1), $urandom());
        else if (r < 60) plan_search(plan_table[$urandom_range(0, DEPTH - 1)]);
        else if (r < 72) plan_search(plan_table[$urandom_range(0, DEPTH - 1)] + 1);
        else if (r < 84) plan_search(plan_table[$urandom_range(0, DEPTH - 1)] - 1);
        else if (r < 94) plan_search($urandom());
        else plan_search(r[0] ? VAL_MAX : VAL_MIN);
      end
    end

    wait_idle();
    if (faults == 0 && pending_lookups.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
